@@ design/chunked_byte_ring_buffer_defines.svh @@
// assertion macros used by the chunked byte ring buffer back end
`ifndef CHUNKED_BYTE_RING_BUFFER_DEFINES_SVH
`define CHUNKED_BYTE_RING_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define CBRB_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cbrb assertion failed");

// consequent holds in the same cycle as the antecedent
`define CBRB_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbrb assertion failed");

// consequent holds in the cycle after the antecedent
`define CBRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbrb assertion failed");

`else

`define CBRB_ASSERT_ALWAYS(label, clk, rst, cond)
`define CBRB_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define CBRB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/cbrb_pkg.sv @@
// shared types and codes of the chunked byte ring buffer
`timescale 1ns / 1ps

package cbrb_pkg;

  localparam int OPC_W  = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 13;
  localparam int OCC_W  = 13;
  localparam int KIND_W = 3;

  // input opcodes
  localparam logic [OPC_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPC_W-1:0] OP_GET   = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DATA    = 3'd0,
    KIND_ACCEPT  = 3'd1,
    KIND_REJECT  = 3'd2,
    KIND_EMPTY   = 3'd3,
    KIND_CLEARED = 3'd4
  } kind_t;

  // commands passed from front to back
  typedef enum logic [1:0] {
    CMD_PUT,
    CMD_GET,
    CMD_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [OCC_W-1:0]  occ;
  } res_t;

  typedef enum logic {
    BK_IDLE,
    BK_GET
  } back_state_t;

  // result queue in the back end
  localparam int RES_DEPTH = 4;
  localparam int RES_PW    = 2;
  localparam int RES_CW    = 3;

endpackage

@@ design/cbrb_front.sv @@
// front end: accepts input transactions, classifies them and queues commands
`timescale 1ns / 1ps

module cbrb_front #(
  parameter int MAX_REQUEST = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cbrb_pkg::OPC_W-1:0]  opcode,
  input  logic [cbrb_pkg::BYTE_W-1:0] data_byte,
  input  logic [cbrb_pkg::LEN_W-1:0]  length,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output cbrb_pkg::cmd_t             cmd
);
  import cbrb_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  cmd_t       cls;
  logic       keep;
  logic       push;
  logic       pop;

  // opcode 3 is dropped without a command
  always_comb begin
    cls      = '0;
    keep     = 1'b1;
    cls.data = data_byte;
    cls.len  = length;
    unique case (opcode)
      OP_PUT: cls.op = CMD_PUT;
      OP_GET: begin
        cls.op  = CMD_GET;
        cls.len = (length > LEN_W'(MAX_REQUEST)) ? LEN_W'(MAX_REQUEST) : length;
      end
      OP_CLEAR: cls.op = CMD_CLEAR;
      default: keep = 1'b0;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready && keep;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

endmodule

@@ design/cbrb_back.sv @@
// back end: byte store, pointers, chunk admission, get sequencer and result queue
`timescale 1ns / 1ps
`include "chunked_byte_ring_buffer_defines.svh"

module cbrb_back #(
  parameter int BUFFER_BYTES = 4096,
  parameter int MAX_REQUEST  = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  cbrb_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output cbrb_pkg::res_t res
);
  import cbrb_pkg::*;

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;
  localparam int RW = $clog2(MAX_REQUEST + 1);

  back_state_t       state;
  back_state_t       state_next;
  logic [CW-1:0]     held;
  logic [CW-1:0]     held_next;
  logic [PW-1:0]     rptr;
  logic [PW-1:0]     rptr_next;
  logic [PW-1:0]     wptr;
  logic [PW-1:0]     wptr_next;
  logic [LEN_W-1:0]  progress;
  logic [LEN_W-1:0]  progress_next;
  logic              admitted;
  logic              admitted_next;
  logic [RW-1:0]     remaining;
  logic [RW-1:0]     remaining_next;
  logic              infl_v;
  logic              infl_last;
  logic              infl_last_next;
  logic [OCC_W-1:0]  infl_occ;
  logic [OCC_W-1:0]  infl_occ_next;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] mem [BUFFER_BYTES];

  res_t              rq [RES_DEPTH];
  logic [RES_PW-1:0] rq_wp;
  logic [RES_PW-1:0] rq_rp;
  logic [RES_CW-1:0] rq_count;

  logic              room;
  logic              issue_ok;
  logic              go;
  logic [LW-1:0]     free;
  logic [CW-1:0]     held_inc;
  logic [CW-1:0]     held_dec;
  logic [PW-1:0]     wptr_adv;
  logic [PW-1:0]     rptr_adv;
  logic [LW-1:0]     n_full;
  logic [RW-1:0]     get_n;
  logic              mem_we;
  logic              mem_re;
  logic              st_push;
  res_t              st_res;
  logic              push;
  res_t              push_d;
  logic              pop;

  assign room     = (rq_count < RES_CW'(RES_DEPTH));
  // a read lands in the cycle after issue, so leave a slot for it
  assign issue_ok = ((rq_count + RES_CW'(infl_v)) <= RES_CW'(RES_DEPTH - 2));
  assign go       = (state == BK_IDLE) && cmd_valid && !infl_v && room;
  assign free     = LW'(BUFFER_BYTES) - LW'(held);
  assign held_inc = held + CW'(1);
  assign held_dec = held - CW'(1);
  assign wptr_adv = (wptr == PW'(BUFFER_BYTES - 1)) ? '0 : wptr + PW'(1);
  assign rptr_adv = (rptr == PW'(BUFFER_BYTES - 1)) ? '0 : rptr + PW'(1);
  assign n_full   = (LW'(cmd.len) < LW'(held)) ? LW'(cmd.len) : LW'(held);
  assign get_n    = RW'(n_full);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (go && cmd.op == CMD_GET && get_n != '0) state_next = BK_GET;
      end
      BK_GET: begin
        if (issue_ok && remaining == RW'(1)) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // command execution
  always_comb begin
    logic [LEN_W-1:0] eff_prog;
    logic [LEN_W-1:0] prog_dec;
    logic             eff_adm;
    logic [CW-1:0]    held_after;

    eff_prog       = '0;
    prog_dec       = '0;
    eff_adm        = 1'b0;
    held_after     = held;
    cmd_ready      = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    st_push        = 1'b0;
    st_res         = '0;
    st_res.last    = 1'b1;
    held_next      = held;
    wptr_next      = wptr;
    rptr_next      = rptr;
    progress_next  = progress;
    admitted_next  = admitted;
    remaining_next = remaining;
    infl_last_next = infl_last;
    infl_occ_next  = infl_occ;

    unique case (state)
      BK_IDLE: begin
        if (go) begin
          cmd_ready = 1'b1;
          unique case (cmd.op)
            CMD_PUT: begin
              if (progress == '0 && cmd.len == '0) begin
                // zero length chunk is refused at once
                st_push       = 1'b1;
                st_res.kind   = KIND_REJECT;
                st_res.occ    = OCC_W'(held);
                admitted_next = 1'b0;
              end else begin
                eff_prog = (progress == '0) ? cmd.len : progress;
                eff_adm  = (progress == '0) ? (LW'(cmd.len) <= free) : admitted;
                if (eff_adm && held < CW'(BUFFER_BYTES)) begin
                  mem_we     = 1'b1;
                  wptr_next  = wptr_adv;
                  held_after = held_inc;
                end
                held_next     = held_after;
                prog_dec      = eff_prog - LEN_W'(1);
                progress_next = prog_dec;
                if (prog_dec == '0) begin
                  st_push       = 1'b1;
                  st_res.kind   = eff_adm ? KIND_ACCEPT : KIND_REJECT;
                  st_res.occ    = OCC_W'(held_after);
                  admitted_next = 1'b0;
                end else begin
                  admitted_next = eff_adm;
                end
              end
            end
            CMD_GET: begin
              if (get_n == '0) begin
                st_push     = 1'b1;
                st_res.kind = KIND_EMPTY;
                st_res.occ  = OCC_W'(held);
              end else begin
                remaining_next = get_n;
              end
            end
            CMD_CLEAR: begin
              st_push       = 1'b1;
              st_res.kind   = KIND_CLEARED;
              st_res.occ    = '0;
              held_next     = '0;
              wptr_next     = '0;
              rptr_next     = '0;
              progress_next = '0;
              admitted_next = 1'b0;
            end
            default: ;
          endcase
        end
      end
      BK_GET: begin
        if (issue_ok) begin
          mem_re         = 1'b1;
          rptr_next      = rptr_adv;
          held_next      = held_dec;
          remaining_next = remaining - RW'(1);
          infl_last_next = (remaining == RW'(1));
          infl_occ_next  = OCC_W'(held_dec);
        end
      end
      default: ;
    endcase
  end

  // result queue: a landing read and a status result never coincide
  assign push      = infl_v || st_push;
  assign push_d    = infl_v ? res_t'{kind: KIND_DATA, data: rd_data, last: infl_last,
                                     occ: infl_occ}
                            : st_res;
  assign res_valid = (rq_count != '0);
  assign pop       = res_valid && res_ready;
  assign res       = rq[rq_rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      held      <= '0;
      rptr      <= '0;
      wptr      <= '0;
      progress  <= '0;
      admitted  <= 1'b0;
      remaining <= '0;
      infl_v    <= 1'b0;
      rq_wp     <= '0;
      rq_rp     <= '0;
      rq_count  <= '0;
    end else begin
      state     <= state_next;
      held      <= held_next;
      rptr      <= rptr_next;
      wptr      <= wptr_next;
      progress  <= progress_next;
      admitted  <= admitted_next;
      remaining <= remaining_next;
      infl_v    <= mem_re;
      if (push) rq_wp <= rq_wp + RES_PW'(1);
      if (pop)  rq_rp <= rq_rp + RES_PW'(1);
      unique case ({push, pop})
        2'b10:   rq_count <= rq_count + RES_CW'(1);
        2'b01:   rq_count <= rq_count - RES_CW'(1);
        default: rq_count <= rq_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    infl_last <= infl_last_next;
    infl_occ  <= infl_occ_next;
    if (push) rq[rq_wp] <= push_d;
  end

  // byte store
  always_ff @(posedge clk) begin
    if (mem_we) mem[wptr] <= cmd.data;
    if (mem_re) rd_data <= mem[rptr];
  end

  `CBRB_ASSERT_ALWAYS(a_held_bound, clk, rst, held <= CW'(BUFFER_BYTES))
  `CBRB_ASSERT_IMPLIES(a_land_room, clk, rst, infl_v, rq_count < RES_CW'(RES_DEPTH))
  `CBRB_ASSERT_IMPLIES(a_get_remaining, clk, rst, state == BK_GET, remaining != '0)
  `CBRB_ASSERT_IMPLIES(a_empty_ptrs, clk, rst, held == '0, rptr == wptr)
  `CBRB_ASSERT_NEXT(a_clear_empties, clk, rst, cmd_valid && cmd_ready && cmd.op == CMD_CLEAR, held == '0 && progress == '0)

endmodule

@@ design/chunked_byte_ring_buffer.sv @@
// top level of the chunked byte ring buffer
//
// usage: byte ring buffer written one chunk at a time, read by requests
// - input channel (in_valid/in_ready): opcode put, get or clear; a put
//   carries one chunk byte, its first byte also the declared chunk length
// - output channel (out_valid/out_ready): results with kind, data_out, last
//   and occupancy; results come out in the order of their transactions
// - a put byte is taken each cycle while in_ready is high; a status result
//   (chunk accepted or rejected, nothing to read, cleared) passes through
//   the command queue and the result queue after its transaction is taken
// - a get streams min(request, held) bytes, at most MAX_REQUEST, one byte per
//   cycle while the receiver keeps up; the first byte passes through the
//   sequencer's get state and the registered read of the byte store
// - one command is carried out at a time in the back end; a two entry
//   command queue and a four entry result queue decouple the two channels
// - reset empties the buffer and closes any open chunk; store contents
//   are left as they are and need no clearing pass
// - a stalled receiver fills the result queue, then the back end and
//   finally the command queue hold, and in_ready drops
`timescale 1ns / 1ps

module chunked_byte_ring_buffer #(
  parameter int BUFFER_BYTES = 4096,
  parameter int MAX_REQUEST  = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cbrb_pkg::OPC_W-1:0]  opcode,
  input  logic [cbrb_pkg::BYTE_W-1:0] data_byte,
  input  logic [cbrb_pkg::LEN_W-1:0]  length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cbrb_pkg::KIND_W-1:0] kind,
  output logic [cbrb_pkg::BYTE_W-1:0] data_out,
  output logic                        last,
  output logic [cbrb_pkg::OCC_W-1:0]  occupancy
);
  import cbrb_pkg::*;

  // command handoff between front and back
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // head of the result queue
  res_t res;

  // front: classifies opcodes, saturates get requests, queues commands
  cbrb_front #(
    .MAX_REQUEST (MAX_REQUEST)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .data_byte (data_byte),
    .length    (length),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // back: holds the store and all buffer state, emits results
  cbrb_back #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_REQUEST  (MAX_REQUEST)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  // unpack the result onto the output fields
  assign kind      = res.kind;
  assign data_out  = res.data;
  assign last      = res.last;
  assign occupancy = res.occ;

endmodule
